// ===== rtl/constant_alpha_fill_blend_macros.svh =====
// assertion macros used by the blend top level
`ifndef CONSTANT_ALPHA_FILL_BLEND_MACROS_SVH
`define CONSTANT_ALPHA_FILL_BLEND_MACROS_SVH

// same-cycle implication, checked on clk_i, quiet in reset
`define CAFB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cafb assertion failed");

// next-cycle implication, checked on clk_i, quiet in reset
`define CAFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cafb assertion failed");

`endif

// ===== rtl/cafb_pkg.sv =====
// types and constants of the constant alpha fill blend
`timescale 1ns / 1ps
`default_nettype none

package cafb_pkg;

  typedef enum logic [1:0] {
    FMT_332  = 2'd0,
    FMT_565  = 2'd1,
    FMT_888  = 2'd2,
    FMT_X888 = 2'd3
  } pix_fmt_e;

  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] REG_FILL_COLOR   = 2'd1;
  localparam logic [1:0] REG_ALPHA_LEVEL  = 2'd2;

  localparam int unsigned CfgDataW = 24;

  localparam logic [31:0] MASK_332  = 32'h0000_38E3;
  localparam logic [31:0] MASK_565  = 32'h07E0_F81F;
  localparam logic [31:0] MASK_RB   = 32'h00FF_00FF;
  localparam logic [31:0] MASK_G    = 32'h0000_FF00;
  localparam logic [31:0] MASK_BYTE = 32'h0000_00FF;

  localparam logic [3:0] SHIFT_332  = 4'd3;
  localparam logic [3:0] SHIFT_565  = 4'd5;
  localparam logic [3:0] SHIFT_BYTE = 4'd8;

  // operands of one blend lane
  typedef struct packed {
    logic [31:0] dst;
    logic [31:0] fill;
    logic [7:0]  alpha;
    logic [3:0]  shift;
    logic [31:0] mask;
  } lane_op_t;

endpackage

`default_nettype wire

// ===== rtl/constant_alpha_fill_blend.sv =====
// constant alpha fill blend, top level
// an input beat passes the input register, then the result register, to its result beat on the master side
// throughput: one pixel per cycle while the master side accepts, three 32x8 blend lanes work in parallel
// an input register and a result register part the two stream sides
// reset clears valid flags and all config registers to zero
`timescale 1ns / 1ps
`default_nettype none
`include "constant_alpha_fill_blend_macros.svh"

module constant_alpha_fill_blend (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [cafb_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] dest_pixel
  input  wire logic        s_axis_tlast,   // end_of_span
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [31:0] blended_pixel
  output      logic        m_axis_tlast    // span_done
);

  cafb_pkg::pix_fmt_e fmt_q;
  logic [23:0] fill_q;
  logic [7:0]  alpha_q;

  logic        in_valid_q;
  logic [31:0] in_pix_q;
  logic        in_last_q;
  logic        out_ready;
  logic        s_beat;

  logic [31:0] blend_d;
  logic [31:0] out_pix_q;
  logic        out_last_q;
  logic        out_valid_q;

  cafb_pkg::lane_op_t op0, op1, op2;
  logic [31:0] res0, res1, res2;

  logic [31:0] fill_332, dst_332, fill_565, dst_565;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= cafb_pkg::FMT_332;
      fill_q  <= '0;
      alpha_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cafb_pkg::REG_PIXEL_FORMAT: fmt_q   <= cafb_pkg::pix_fmt_e'(cfg_data_i[1:0]);
        cafb_pkg::REG_FILL_COLOR:   fill_q  <= cfg_data_i[23:0];
        cafb_pkg::REG_ALPHA_LEVEL:  alpha_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_pix_q  <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // spread fields
  assign fill_332 = ({24'd0, fill_q[7:0]} | {15'd0, fill_q[7:0], 9'd0}) & cafb_pkg::MASK_332;
  assign dst_332  = ({24'd0, in_pix_q[7:0]} | {15'd0, in_pix_q[7:0], 9'd0})
                    & cafb_pkg::MASK_332;
  assign fill_565 = ({16'd0, fill_q[15:0]} | {fill_q[15:0], 16'd0}) & cafb_pkg::MASK_565;
  assign dst_565  = ({16'd0, in_pix_q[15:0]} | {in_pix_q[15:0], 16'd0})
                    & cafb_pkg::MASK_565;

  // lane operands
  always_comb begin
    op1.dst   = {24'd0, in_pix_q[15:8]};
    op1.fill  = {24'd0, fill_q[15:8]};
    op1.alpha = alpha_q;
    op1.shift = cafb_pkg::SHIFT_BYTE;
    op1.mask  = cafb_pkg::MASK_BYTE;
    op2.dst   = {24'd0, in_pix_q[23:16]};
    op2.fill  = {24'd0, fill_q[23:16]};
    op2.alpha = alpha_q;
    op2.shift = cafb_pkg::SHIFT_BYTE;
    op2.mask  = cafb_pkg::MASK_BYTE;
    op0.dst   = {24'd0, in_pix_q[7:0]};
    op0.fill  = {24'd0, fill_q[7:0]};
    op0.alpha = alpha_q;
    op0.shift = cafb_pkg::SHIFT_BYTE;
    op0.mask  = cafb_pkg::MASK_BYTE;
    unique case (fmt_q)
      cafb_pkg::FMT_332: begin
        op0.dst   = dst_332;
        op0.fill  = fill_332;
        op0.alpha = {5'd0, alpha_q[7:5]};
        op0.shift = cafb_pkg::SHIFT_332;
        op0.mask  = cafb_pkg::MASK_332;
      end
      cafb_pkg::FMT_565: begin
        op0.dst   = dst_565;
        op0.fill  = fill_565;
        op0.alpha = {3'd0, alpha_q[7:3]};
        op0.shift = cafb_pkg::SHIFT_565;
        op0.mask  = cafb_pkg::MASK_565;
      end
      cafb_pkg::FMT_888: ;
      cafb_pkg::FMT_X888: begin
        op0.dst  = in_pix_q & cafb_pkg::MASK_RB;
        op0.fill = {8'd0, fill_q} & cafb_pkg::MASK_RB;
        op0.mask = cafb_pkg::MASK_RB;
        op1.dst  = in_pix_q & cafb_pkg::MASK_G;
        op1.fill = {8'd0, fill_q} & cafb_pkg::MASK_G;
        op1.mask = cafb_pkg::MASK_G;
      end
      default: ;
    endcase
  end

  cafb_lane u_lane0 (.op_i(op0), .res_o(res0));
  cafb_lane u_lane1 (.op_i(op1), .res_o(res1));
  cafb_lane u_lane2 (.op_i(op2), .res_o(res2));

  // pack result
  always_comb begin
    unique case (fmt_q)
      cafb_pkg::FMT_332:  blend_d = {24'd0, res0[7:0] | res0[16:9]};
      cafb_pkg::FMT_565:  blend_d = {16'd0, res0[15:0] | res0[31:16]};
      cafb_pkg::FMT_888:  blend_d = {8'd0, res2[7:0], res1[7:0], res0[7:0]};
      cafb_pkg::FMT_X888: blend_d = res0 | res1;
      default:            blend_d = res0 | res1;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_pix_q  <= blend_d;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  `CAFB_ASSERT_NEXT(a_beat_loads_input, s_beat, in_valid_q)
  `CAFB_ASSERT_NEXT(a_input_moves_out, in_valid_q, out_valid_q)
  `CAFB_ASSERT_NEXT(a_stalled_input_holds, in_valid_q && !out_ready,
                    in_valid_q && $stable(in_pix_q) && $stable(in_last_q))

endmodule

`default_nettype wire

// ===== rtl/cafb_lane.sv =====
// one blend lane: dst + ((alpha * (fill - dst)) >> shift), masked
`timescale 1ns / 1ps
`default_nettype none

module cafb_lane (
  input  wire cafb_pkg::lane_op_t op_i,
  output logic [31:0]             res_o
);

  logic [31:0] diff;
  logic [31:0] prod;
  logic [31:0] scaled;
  logic [31:0] sum;

  // all math wraps at 32 bits
  assign diff   = op_i.fill - op_i.dst;
  assign prod   = diff * {24'd0, op_i.alpha};
  assign scaled = prod >> op_i.shift;
  assign sum    = op_i.dst + scaled;
  assign res_o  = sum & op_i.mask;

endmodule

`default_nettype wire

// ===== verif/cafb_checker.sv =====
// beat monitor and expected-pixel comparison for the constant alpha fill blend
`timescale 1ns / 1ps

module cafb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int          mismatch_count_o,
  output int          pending_o
);
  import cafb_pkg::*;

  typedef struct packed {
    logic [31:0] pixel;
    logic        span_done;
  } out_pix_t;

  pix_fmt_e    fmt_q;
  logic [23:0] fill_q;
  logic [7:0]  alpha_q;
  out_pix_t    blended_q[$];

  // one weighted lane: dst + ((w * (fill - dst)) >> sh), 32-bit wraparound
  function automatic logic [31:0] lane_mix(logic [31:0] dst, logic [31:0] fill,
                                           logic [31:0] wgt, logic [3:0] sh,
                                           logic [31:0] mask);
    logic [31:0] diff;
    logic [31:0] prod;
    diff = fill - dst;
    prod = wgt * diff;
    return (dst + (prod >> sh)) & mask;
  endfunction

  function automatic logic [31:0] blend_pixel(pix_fmt_e fmt, logic [23:0] fill,
                                              logic [7:0] alpha, logic [31:0] dst);
    logic [31:0] f;
    logic [31:0] d;
    logic [31:0] w;
    logic [31:0] r;
    f = {8'h00, fill};
    r = 32'h0;
    case (fmt)
      FMT_332: begin
        w = {24'h0, alpha} >> 5;
        f = f & MASK_BYTE;
        d = dst & MASK_BYTE;
        r = lane_mix((d | (d << 9)) & MASK_332, (f | (f << 9)) & MASK_332,
                     w, SHIFT_332, MASK_332);
        r = (r | (r >> 9)) & MASK_BYTE;
      end
      FMT_565: begin
        w = {24'h0, alpha} >> 3;
        f = f & 32'h0000_FFFF;
        d = dst & 32'h0000_FFFF;
        r = lane_mix((d | (d << 16)) & MASK_565, (f | (f << 16)) & MASK_565,
                     w, SHIFT_565, MASK_565);
        r = (r | (r >> 16)) & 32'h0000_FFFF;
      end
      FMT_888: begin
        w = {24'h0, alpha};
        for (int i = 0; i < 3; i++) begin
          r = r | (lane_mix((dst >> (8 * i)) & MASK_BYTE, (f >> (8 * i)) & MASK_BYTE,
                            w, SHIFT_BYTE, MASK_BYTE) << (8 * i));
        end
      end
      default: begin
        w = {24'h0, alpha};
        r = lane_mix(dst & MASK_RB, f & MASK_RB, w, SHIFT_BYTE, MASK_RB)
          | lane_mix(dst & MASK_G, f & MASK_G, w, SHIFT_BYTE, MASK_G);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_pix_t want;
    if (!rst_ni) begin
      fmt_q            = FMT_332;
      fill_q           = '0;
      alpha_q          = '0;
      blended_q.delete();
      mismatch_count_o = 0;
      pending_o       <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (blended_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none got %h last %b",
                   $time, m_tdata_i, m_tlast_i);
          mismatch_count_o++;
        end else begin
          want = blended_q.pop_front();
          if (m_tdata_i !== want.pixel) begin
            $display("%0t: blended_pixel expected %h got %h", $time, want.pixel, m_tdata_i);
            mismatch_count_o++;
          end
          if (m_tlast_i !== want.span_done) begin
            $display("%0t: span_done expected %b got %b", $time, want.span_done, m_tlast_i);
            mismatch_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        want.pixel     = blend_pixel(fmt_q, fill_q, alpha_q, s_tdata_i);
        want.span_done = s_tlast_i;
        blended_q.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PIXEL_FORMAT: fmt_q   = pix_fmt_e'(cfg_data_i[1:0]);
          REG_FILL_COLOR:   fill_q  = cfg_data_i;
          REG_ALPHA_LEVEL:  alpha_q = cfg_data_i[7:0];
          default: ;
        endcase
      end
      pending_o <= blended_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// stimulus, reset, clock and verdict for the constant alpha fill blend
`timescale 1ns / 1ps

module testbench;
  import cafb_pkg::*;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  int          mismatches;
  int          pending;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          stall_burst;

  constant_alpha_fill_blend dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  cafb_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tlast_i        (s_tlast),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tlast_i        (m_tlast),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("constant_alpha_fill_blend regression: fail");
    $finish;
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_burst > 0) begin
        m_tready <= 1'b0;
        stall_burst--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_blend(input pix_fmt_e fmt, input logic [23:0] fill,
                           input logic [7:0] alpha);
    logic [31:0] junk;
    junk = $urandom;
    reg_write(REG_PIXEL_FORMAT, {junk[21:0], fmt});
    reg_write(REG_FILL_COLOR, fill);
    reg_write(REG_ALPHA_LEVEL, {junk[31:16], alpha});
  endtask

  task automatic send_pixel(input logic [31:0] px, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    pix_fmt_e    fmt;
    logic [23:0] fill;
    logic [7:0]  alpha;
    logic [31:0] px;

    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_burst    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: 332 with zero fill and zero alpha
    send_pixel(32'hFFFF_FFC3, 1'b1);
    drain();

    // every format at full and zero weight with stray high fill bits
    for (int f = 0; f < 4; f++) begin
      set_blend(pix_fmt_e'(f), 24'hFF_FFFF, 8'hFF);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'hA5A5_A5A5, 1'b0);
      drain();
      reg_write(REG_ALPHA_LEVEL, 24'h0);
      send_pixel(32'h1234_5678, 1'b1);
      drain();
    end

    // fill below destination in every field
    set_blend(FMT_X888, 24'h00_0000, 8'h80);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    drain();
    set_blend(FMT_332, 24'hFF_FF00, 8'hE0);
    send_pixel(32'h0000_00FF, 1'b1);
    drain();

    // unmapped register index leaves the setup alone
    reg_write(REG_UNMAPPED, 24'hFF_FFFF);
    send_pixel(32'h0000_0081, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int s = 0; s < 6; s++) begin
        fmt = pix_fmt_e'((ph + s) % 4);
        case ($urandom_range(3))
          0: fill = 24'h00_0000;
          1: fill = 24'hFF_FFFF;
          default: fill = 24'($urandom);
        endcase
        case ($urandom_range(4))
          0: alpha = 8'h00;
          1: alpha = 8'hFF;
          default: alpha = 8'($urandom);
        endcase
        set_blend(fmt, fill, alpha);
        if (ph == 0 && s == 2) stall_burst = 300;
        for (int n = 0; n < 48; n++) begin
          case ($urandom_range(9))
            0: px = 32'h0000_0000;
            1: px = 32'hFFFF_FFFF;
            default: px = $urandom;
          endcase
          send_pixel(px, $urandom_range(7) == 0);
        end
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("constant_alpha_fill_blend regression: pass");
    end else begin
      $display("constant_alpha_fill_blend regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cafb_pkg.sv
rtl/cafb_lane.sv
rtl/constant_alpha_fill_blend.sv
verif/cafb_checker.sv
verif/testbench.sv
